// ----- hw/rtl/vfe_pkg.sv -----
// shared constants and types for the volume fade engine
package vfe_pkg;

   // channel counts
   localparam int VOICE_COUNT = 24;
   localparam int SLOT_COUNT  = 5;

   localparam int VOICE_IDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
   localparam int SLOT_IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   // field widths
   localparam int OP_W      = 2;
   localparam int INDEX_W   = 5;
   localparam int MODE_W    = 2;
   localparam int LEVEL_W   = 7;
   localparam int STEP_W    = 7;
   localparam int TICKS_W   = 15;
   localparam int SOURCE_W  = 2;
   localparam int CHANNEL_W = 5;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'h7F;

   // slot interpolation product and divider
   localparam int PROD_W    = LEVEL_W + TICKS_W;
   localparam int DIV_CNT_W = $clog2(PROD_W + 1);

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // command codes
   localparam logic [OP_W-1:0] OP_TICK       = 2'd0;
   localparam logic [OP_W-1:0] OP_SET_MASTER = 2'd1;
   localparam logic [OP_W-1:0] OP_SET_VOICE  = 2'd2;
   localparam logic [OP_W-1:0] OP_SLOT_START = 2'd3;

   // fade modes
   localparam logic [MODE_W-1:0] MODE_HOLD = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DOWN = 2'd1;
   localparam logic [MODE_W-1:0] MODE_UP   = 2'd2;

   // result sources
   localparam logic [SOURCE_W-1:0] SRC_MASTER = 2'd0;
   localparam logic [SOURCE_W-1:0] SRC_VOICE  = 2'd1;
   localparam logic [SOURCE_W-1:0] SRC_SLOT   = 2'd2;

   // register indexes
   localparam logic REG_MASTER_STEP = 1'b0;
   localparam logic REG_VOICE_STEP  = 1'b1;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [LEVEL_W-1:0] left;
      logic [LEVEL_W-1:0] right;
   } pair_type;

   typedef struct packed {
      logic               start;
      logic [PROD_W-1:0]  dividend;
      logic [TICKS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic [STEP_W-1:0] master_step;
      logic [STEP_W-1:0] voice_step;
   } steps_type;

endpackage

// ----- hw/rtl/vfe_csr.sv -----
// step registers behind the apb-style configuration port
module vfe_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [vfe_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [vfe_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [vfe_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output vfe_pkg::steps_type             steps
);
   import vfe_pkg::*;

   logic [STEP_W-1:0] master_step_ff, master_step_in;
   logic [STEP_W-1:0] voice_step_ff, voice_step_in;
   logic              write_en;
   logic              reg_sel;

   assign pready   = 1'b1;
   assign write_en = psel & penable & pwrite & pready;
   assign reg_sel  = paddr[CSR_ADDR_W-1];

   // register write decode
   always_comb begin
      master_step_in = master_step_ff;
      voice_step_in  = voice_step_ff;
      if (write_en) begin
         unique case (reg_sel)
            REG_MASTER_STEP: master_step_in = pwdata[STEP_W-1:0];
            REG_VOICE_STEP:  voice_step_in  = pwdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (reg_sel)
         REG_MASTER_STEP: prdata = CSR_DATA_W'(master_step_ff);
         REG_VOICE_STEP:  prdata = CSR_DATA_W'(voice_step_ff);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         master_step_ff <= '0;
         voice_step_ff  <= '0;
      end else begin
         master_step_ff <= master_step_in;
         voice_step_ff  <= voice_step_in;
      end
   end

   assign steps.master_step = master_step_ff;
   assign steps.voice_step  = voice_step_ff;

endmodule

// ----- hw/rtl/vfe_level_step.sv -----
// shared fade step unit: moves one level pair down or up by a step and clamps
module vfe_level_step (
   input  vfe_pkg::pair_type                pair_i,
   input  logic [vfe_pkg::STEP_W-1:0]       step,
   output vfe_pkg::pair_type                pair_o,
   output logic                             moved
);
   import vfe_pkg::*;

   logic [LEVEL_W:0]   left_sum;
   logic [LEVEL_W:0]   right_sum;
   logic [LEVEL_W-1:0] left_new;
   logic [LEVEL_W-1:0] right_new;

   assign left_sum  = (LEVEL_W+1)'(pair_i.left) + (LEVEL_W+1)'(step);
   assign right_sum = (LEVEL_W+1)'(pair_i.right) + (LEVEL_W+1)'(step);

   always_comb begin
      pair_o    = pair_i;
      moved     = 1'b0;
      left_new  = pair_i.left;
      right_new = pair_i.right;
      case (pair_i.mode)
         // fade down, floor at zero
         MODE_DOWN: begin
            moved     = 1'b1;
            left_new  = (pair_i.left > step) ? pair_i.left - step : '0;
            right_new = (pair_i.right > step) ? pair_i.right - step : '0;
            pair_o.left  = left_new;
            pair_o.right = right_new;
            if (left_new == '0 && right_new == '0) begin
               pair_o.mode = MODE_HOLD;
            end
         end
         // fade up, ceiling at full scale
         MODE_UP: begin
            moved     = 1'b1;
            left_new  = left_sum[LEVEL_W] ? LEVEL_MAX : left_sum[LEVEL_W-1:0];
            right_new = right_sum[LEVEL_W] ? LEVEL_MAX : right_sum[LEVEL_W-1:0];
            pair_o.left  = left_new;
            pair_o.right = right_new;
            if (left_new == LEVEL_MAX && right_new == LEVEL_MAX) begin
               pair_o.mode = MODE_HOLD;
            end
         end
         // hold and the unused code leave the pair alone
         default: ;
      endcase
   end

endmodule

// ----- hw/rtl/vfe_divider.sv -----
// serial restoring divider, one quotient bit per cycle
module vfe_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  vfe_pkg::div_req_type req,
   output vfe_pkg::div_rsp_type rsp
);
   import vfe_pkg::*;

   logic [PROD_W-1:0]    quo_ff, quo_in;
   logic [TICKS_W:0]     rem_ff, rem_in;
   logic [TICKS_W-1:0]   divisor_ff, divisor_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [TICKS_W:0]     rem_shift;
   logic                 fits;

   // one trial subtraction per cycle
   assign rem_shift = {rem_ff[TICKS_W-1:0], quo_ff[PROD_W-1]};
   assign fits      = rem_shift >= {1'b0, divisor_ff};

   always_comb begin
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      count_in   = count_ff;
      run_in     = run_ff;
      done_in    = 1'b0;
      if (req.start) begin
         quo_in     = req.dividend;
         rem_in     = '0;
         divisor_in = req.divisor;
         count_in   = DIV_CNT_W'(PROD_W);
         run_in     = 1'b1;
      end else if (run_ff) begin
         quo_in   = {quo_ff[PROD_W-2:0], fits};
         rem_in   = fits ? rem_shift - {1'b0, divisor_ff} : rem_shift;
         count_in = count_ff - DIV_CNT_W'(1);
         if (count_ff == DIV_CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      count_ff   <= count_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// ----- hw/rtl/volume_fade_engine_unit.sv -----
// volume fade engine top level: command decode, channel sequencer and result output
// A command that sets a master or voice pair, or starts a slot fade, is taken and
// busy stays low; a slot start to a slot in range puts its single result on the
// rsp_ ports in the next cycle. A tick keeps busy high while the sequencer walks the
// master pair, every slot and every voice, the master and voice pairs through one
// shared fade step unit, one channel per cycle while no slot waits on the divider,
// and then closes out the tick. Each slot that is still interpolating runs its level
// through the serial divider one quotient bit per cycle. Each result is held back
// until the next one of the same tick is known, so rsp_last can mark the final result;
// results come out strobed by rsp_valid for one cycle each and cannot be stalled.
// A tick with no active channel gives no result.
module volume_fade_engine_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [vfe_pkg::OP_W-1:0]       req_op,
   input  logic [vfe_pkg::INDEX_W-1:0]    req_index,
   input  logic [vfe_pkg::MODE_W-1:0]     req_mode,
   input  logic [vfe_pkg::LEVEL_W-1:0]    req_left_level,
   input  logic [vfe_pkg::LEVEL_W-1:0]    req_right_level,
   input  logic [vfe_pkg::LEVEL_W-1:0]    req_fade_from,
   input  logic [vfe_pkg::LEVEL_W-1:0]    req_fade_to,
   input  logic [vfe_pkg::TICKS_W-1:0]    req_fade_ticks,
   output logic                           rsp_valid,
   output logic [vfe_pkg::SOURCE_W-1:0]   rsp_source,
   output logic [vfe_pkg::CHANNEL_W-1:0]  rsp_channel,
   output logic [vfe_pkg::LEVEL_W-1:0]    rsp_out_left,
   output logic [vfe_pkg::LEVEL_W-1:0]    rsp_out_right,
   output logic                           rsp_last,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [vfe_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [vfe_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [vfe_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import vfe_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_MASTER   = 7'b0000010,
      ST_SLOT     = 7'b0000100,
      ST_DIV_GO   = 7'b0001000,
      ST_DIV_WAIT = 7'b0010000,
      ST_VOICE    = 7'b0100000,
      ST_FLUSH    = 7'b1000000
   } state_type;

   // sequencer
   state_type              state_ff, state_in;
   logic [SLOT_IDX_W-1:0]  slot_idx_ff, slot_idx_in;
   logic [VOICE_IDX_W-1:0] voice_idx_ff, voice_idx_in;

   // channel state
   pair_type               master_ff, master_in;
   pair_type               voice_ff [VOICE_COUNT];
   pair_type               voice_in [VOICE_COUNT];
   logic [SLOT_COUNT-1:0]  slot_active_ff, slot_active_in;
   logic [LEVEL_W-1:0]     slot_start_ff [SLOT_COUNT];
   logic [LEVEL_W-1:0]     slot_start_in [SLOT_COUNT];
   logic [LEVEL_W-1:0]     slot_target_ff [SLOT_COUNT];
   logic [LEVEL_W-1:0]     slot_target_in [SLOT_COUNT];
   logic [LEVEL_W-1:0]     slot_level_ff [SLOT_COUNT];
   logic [LEVEL_W-1:0]     slot_level_in [SLOT_COUNT];
   logic [TICKS_W-1:0]     slot_length_ff [SLOT_COUNT];
   logic [TICKS_W-1:0]     slot_length_in [SLOT_COUNT];
   logic [TICKS_W-1:0]     slot_elapsed_ff [SLOT_COUNT];
   logic [TICKS_W-1:0]     slot_elapsed_in [SLOT_COUNT];

   // interpolation
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic                   neg_ff, neg_in;

   // held-back result
   logic                   pend_valid_ff, pend_valid_in;
   logic [SOURCE_W-1:0]    pend_source_ff, pend_source_in;
   logic [CHANNEL_W-1:0]   pend_channel_ff, pend_channel_in;
   logic [LEVEL_W-1:0]     pend_left_ff, pend_left_in;
   logic [LEVEL_W-1:0]     pend_right_ff, pend_right_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SOURCE_W-1:0]    rsp_source_ff, rsp_source_in;
   logic [CHANNEL_W-1:0]   rsp_channel_ff, rsp_channel_in;
   logic [LEVEL_W-1:0]     rsp_left_ff, rsp_left_in;
   logic [LEVEL_W-1:0]     rsp_right_ff, rsp_right_in;
   logic                   rsp_last_ff, rsp_last_in;

   // helpers
   steps_type              steps;
   pair_type               step_pair_i;
   pair_type               step_pair_o;
   logic [STEP_W-1:0]      step_amount;
   logic                   step_moved;
   div_req_type            div_req;
   div_rsp_type            div_rsp;
   logic                   accept;
   logic                   push;
   logic [SOURCE_W-1:0]    push_source;
   logic [CHANNEL_W-1:0]   push_channel;
   logic [LEVEL_W-1:0]     push_left;
   logic [LEVEL_W-1:0]     push_right;
   logic                   flush;
   logic                   slot_emit;
   logic [TICKS_W-1:0]     elapsed_inc;
   logic [LEVEL_W-1:0]     diff_mag;
   logic [LEVEL_W-1:0]     quot_lvl;
   logic [LEVEL_W-1:0]     interp_lvl;

   vfe_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .steps   (steps)
   );

   // one fade step unit shared by master and voices
   assign step_pair_i = (state_ff == ST_MASTER) ? master_ff : voice_ff[voice_idx_ff];
   assign step_amount = (state_ff == ST_MASTER) ? steps.master_step : steps.voice_step;

   vfe_level_step u_level_step (
      .pair_i (step_pair_i),
      .step   (step_amount),
      .pair_o (step_pair_o),
      .moved  (step_moved)
   );

   assign div_req.start    = (state_ff == ST_DIV_GO);
   assign div_req.dividend = prod_ff;
   assign div_req.divisor  = slot_length_ff[slot_idx_ff];

   vfe_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start & ~busy;

   // slot interpolation terms
   assign elapsed_inc = slot_elapsed_ff[slot_idx_ff] + TICKS_W'(1);
   assign diff_mag    = (slot_target_ff[slot_idx_ff] >= slot_start_ff[slot_idx_ff]) ?
                        slot_target_ff[slot_idx_ff] - slot_start_ff[slot_idx_ff] :
                        slot_start_ff[slot_idx_ff] - slot_target_ff[slot_idx_ff];
   assign quot_lvl    = div_rsp.quotient[LEVEL_W-1:0];
   assign interp_lvl  = neg_ff ? slot_start_ff[slot_idx_ff] - quot_lvl :
                                 slot_start_ff[slot_idx_ff] + quot_lvl;

   // sequencer and channel updates
   always_comb begin
      state_in        = state_ff;
      slot_idx_in     = slot_idx_ff;
      voice_idx_in    = voice_idx_ff;
      master_in       = master_ff;
      voice_in        = voice_ff;
      slot_active_in  = slot_active_ff;
      slot_start_in   = slot_start_ff;
      slot_target_in  = slot_target_ff;
      slot_level_in   = slot_level_ff;
      slot_length_in  = slot_length_ff;
      slot_elapsed_in = slot_elapsed_ff;
      prod_in         = prod_ff;
      neg_in          = neg_ff;
      push            = 1'b0;
      push_source     = SRC_MASTER;
      push_channel    = '0;
      push_left       = step_pair_o.left;
      push_right      = step_pair_o.right;
      flush           = 1'b0;
      slot_emit       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_TICK: state_in = ST_MASTER;
                  OP_SET_MASTER: begin
                     master_in.mode  = req_mode;
                     master_in.left  = req_left_level;
                     master_in.right = req_right_level;
                  end
                  OP_SET_VOICE: begin
                     if (int'(req_index) < VOICE_COUNT) begin
                        voice_in[VOICE_IDX_W'(req_index)].mode  = req_mode;
                        voice_in[VOICE_IDX_W'(req_index)].left  = req_left_level;
                        voice_in[VOICE_IDX_W'(req_index)].right = req_right_level;
                     end
                  end
                  default: begin
                     if (int'(req_index) < SLOT_COUNT) begin
                        slot_start_in[SLOT_IDX_W'(req_index)]   = req_fade_from;
                        slot_target_in[SLOT_IDX_W'(req_index)]  = req_fade_to;
                        slot_level_in[SLOT_IDX_W'(req_index)]   = req_fade_from;
                        slot_length_in[SLOT_IDX_W'(req_index)]  = req_fade_ticks;
                        slot_elapsed_in[SLOT_IDX_W'(req_index)] = '0;
                        slot_active_in[SLOT_IDX_W'(req_index)]  = 1'b1;
                        slot_emit = 1'b1;
                     end
                  end
               endcase
            end
         end
         ST_MASTER: begin
            master_in    = step_pair_o;
            push         = step_moved;
            push_source  = SRC_MASTER;
            push_channel = '0;
            slot_idx_in  = '0;
            state_in     = ST_SLOT;
         end
         ST_SLOT: begin
            if (slot_active_ff[slot_idx_ff]) begin
               slot_elapsed_in[slot_idx_ff] = elapsed_inc;
               if (elapsed_inc >= slot_length_ff[slot_idx_ff]) begin
                  // fade complete: land on the target
                  slot_level_in[slot_idx_ff]  = slot_target_ff[slot_idx_ff];
                  slot_active_in[slot_idx_ff] = 1'b0;
                  push         = 1'b1;
                  push_source  = SRC_SLOT;
                  push_channel = CHANNEL_W'(slot_idx_ff);
                  push_left    = slot_target_ff[slot_idx_ff];
                  push_right   = slot_target_ff[slot_idx_ff];
               end else begin
                  prod_in  = PROD_W'(diff_mag) * PROD_W'(elapsed_inc);
                  neg_in   = slot_target_ff[slot_idx_ff] < slot_start_ff[slot_idx_ff];
                  state_in = ST_DIV_GO;
               end
            end
            if (!slot_active_ff[slot_idx_ff] ||
                elapsed_inc >= slot_length_ff[slot_idx_ff]) begin
               if (slot_idx_ff == SLOT_IDX_W'(SLOT_COUNT - 1)) begin
                  voice_idx_in = '0;
                  state_in     = ST_VOICE;
               end else begin
                  slot_idx_in = slot_idx_ff + SLOT_IDX_W'(1);
               end
            end
         end
         ST_DIV_GO: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               slot_level_in[slot_idx_ff] = interp_lvl;
               push         = 1'b1;
               push_source  = SRC_SLOT;
               push_channel = CHANNEL_W'(slot_idx_ff);
               push_left    = interp_lvl;
               push_right   = interp_lvl;
               if (slot_idx_ff == SLOT_IDX_W'(SLOT_COUNT - 1)) begin
                  voice_idx_in = '0;
                  state_in     = ST_VOICE;
               end else begin
                  slot_idx_in = slot_idx_ff + SLOT_IDX_W'(1);
                  state_in    = ST_SLOT;
               end
            end
         end
         ST_VOICE: begin
            voice_in[voice_idx_ff] = step_pair_o;
            push         = step_moved;
            push_source  = SRC_VOICE;
            push_channel = CHANNEL_W'(voice_idx_ff);
            if (voice_idx_ff == VOICE_IDX_W'(VOICE_COUNT - 1)) begin
               state_in = ST_FLUSH;
            end else begin
               voice_idx_in = voice_idx_ff + VOICE_IDX_W'(1);
            end
         end
         ST_FLUSH: begin
            flush    = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // result hold-back and output register
   always_comb begin
      pend_valid_in   = pend_valid_ff;
      pend_source_in  = pend_source_ff;
      pend_channel_in = pend_channel_ff;
      pend_left_in    = pend_left_ff;
      pend_right_in   = pend_right_ff;
      rsp_valid_in    = 1'b0;
      rsp_source_in   = pend_source_ff;
      rsp_channel_in  = pend_channel_ff;
      rsp_left_in     = pend_left_ff;
      rsp_right_in    = pend_right_ff;
      rsp_last_in     = 1'b0;
      if (slot_emit) begin
         rsp_valid_in   = 1'b1;
         rsp_source_in  = SRC_SLOT;
         rsp_channel_in = CHANNEL_W'(req_index);
         rsp_left_in    = req_fade_from;
         rsp_right_in   = req_fade_from;
         rsp_last_in    = 1'b1;
      end else if (push) begin
         // a newer result exists, so the held one is not last
         rsp_valid_in    = pend_valid_ff;
         pend_valid_in   = 1'b1;
         pend_source_in  = push_source;
         pend_channel_in = push_channel;
         pend_left_in    = push_left;
         pend_right_in   = push_right;
      end else if (flush) begin
         rsp_valid_in  = pend_valid_ff;
         rsp_last_in   = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         master_ff      <= '0;
         voice_ff       <= '{default: '0};
         slot_active_ff <= '0;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         master_ff      <= master_in;
         voice_ff       <= voice_in;
         slot_active_ff <= slot_active_in;
         pend_valid_ff  <= pend_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      slot_idx_ff     <= slot_idx_in;
      voice_idx_ff    <= voice_idx_in;
      slot_start_ff   <= slot_start_in;
      slot_target_ff  <= slot_target_in;
      slot_level_ff   <= slot_level_in;
      slot_length_ff  <= slot_length_in;
      slot_elapsed_ff <= slot_elapsed_in;
      prod_ff         <= prod_in;
      neg_ff          <= neg_in;
      pend_source_ff  <= pend_source_in;
      pend_channel_ff <= pend_channel_in;
      pend_left_ff    <= pend_left_in;
      pend_right_ff   <= pend_right_in;
      rsp_source_ff   <= rsp_source_in;
      rsp_channel_ff  <= rsp_channel_in;
      rsp_left_ff     <= rsp_left_in;
      rsp_right_ff    <= rsp_right_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_source    = rsp_source_ff;
   assign rsp_channel   = rsp_channel_ff;
   assign rsp_out_left  = rsp_left_ff;
   assign rsp_out_right = rsp_right_ff;
   assign rsp_last      = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // no result may be left behind once the sequencer is idle
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pend_valid_ff)
      else $error("held result left over in idle");

   // the divider only reports while the sequencer waits for it
   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_DIV_WAIT)
      else $error("divider done outside wait state");

   // an accepted tick starts the walk at the master pair
   a_tick_starts_master: assert property (@(posedge clock) disable iff (reset)
      accept && req_op == OP_TICK |=> state_ff == ST_MASTER)
      else $error("tick did not start at master");

   // a result strobe during a tick is never marked last before the walk ends
   a_last_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> $past(state_ff) == ST_FLUSH || $past(state_ff) == ST_IDLE)
      else $error("last result before the end of the item");
`endif

endmodule
